// File: rtl/core/sdce_pkg.sv
// shared types, codes and crc helpers for the sd bus command and response engine
`default_nettype none
package sdce_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 2048;
  localparam int unsigned LONG_RESP_BITS  = 136;
  localparam int unsigned SHORT_RESP_BITS = 48;
  localparam int unsigned CRC7_BITS       = 40;
  localparam int unsigned CMD_BITS        = 48;
  localparam int unsigned CRC16_BITS      = 16;
  localparam int unsigned FIFO_DEPTH      = 4;

  localparam logic [6:0]  CRC7_POLY  = 7'h09;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [1:0]  CMD_START  = 2'b01;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [1:0] RESP_NONE = 2'd0;
  localparam logic [1:0] RESP_R1   = 2'd1;
  localparam logic [1:0] RESP_R2   = 2'd2;
  localparam logic [1:0] RESP_R3   = 2'd3;

  localparam logic [1:0] KIND_CMD_BIT   = 2'd0;
  localparam logic [1:0] KIND_DATA_BYTE = 2'd1;
  localparam logic [1:0] KIND_RESP_WORD = 2'd2;
  localparam logic [1:0] KIND_DONE      = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
  localparam logic [1:0] STATUS_INDEX_ERR = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [1:0]  resp_type;
    logic        data_expected;
    logic [15:0] block_count;
    logic        cmd_level;
    logic        dat_level;
  } sdce_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        cmd_out_bit;
    logic [7:0]  data_byte;
    logic [31:0] resp_word;
    logic [1:0]  word_index;
    logic [1:0]  status;
    logic        last;
  } sdce_out_t;

  // one queued unit of work for the back end
  typedef struct packed {
    logic             is_start;
    logic [39:0]      frame;
    logic [2:0]       num_words;
    logic [3:0][31:0] words;
    logic             byte_valid;
    logic [7:0]       data_byte;
    logic             done;
    logic [1:0]       status;
  } sdce_job_t;

  function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic din);
    logic fb;
    fb = crc[6] ^ din;
    return {crc[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
  endfunction

  // crc16 advanced by one whole byte, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] din);
    logic [15:0] c;
    c = crc ^ {din, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = {c[14:0], 1'b0} ^ (c[15] ? CRC16_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sd_bus_command_response_engine_top.sv
// sd bus engine: one bus tick or command start per cycle in, one result per cycle out while popped
// path: an item's results pass the job queue, the back end's current job and the output register
// throughput: one item per cycle while the four-entry job queue has room; a start item
//   yields 48 or 49 results and so holds the result side until all of them are popped
// reset: synchronous, clears queue, output register and transaction state; block_bytes = 512
`default_nettype none
module sd_bus_command_response_engine_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire sdce_pkg::sdce_in_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output sdce_pkg::sdce_out_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [11:0]         cfg_data
);

  sdce_pkg::sdce_job_t front_job;
  sdce_pkg::sdce_job_t back_job;
  logic                front_job_valid;
  logic                accept;
  logic                job_avail;
  logic                job_take;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // classify and track bus state
  sdce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .accept    (accept),
    .cfg_write (cfg_valid),
    .cfg_data  (cfg_data),
    .job       (front_job),
    .job_valid (front_job_valid)
  );

  // decoupling queue
  sdce_job_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && front_job_valid),
    .wr_data   (front_job),
    .full      (full),
    .rd_en     (job_take),
    .rd_data   (back_job),
    .not_empty (job_avail)
  );

  // result sequencing
  sdce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_avail (job_avail),
    .job_take  (job_take),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

// File: rtl/core/sdce_front.sv
// front end: bus state tracking, response and data checks, job building
`default_nettype none
module sdce_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sdce_pkg::sdce_in_t  in_item,
  input  wire logic                accept,
  input  wire logic                cfg_write,
  input  wire logic [11:0]         cfg_data,
  output sdce_pkg::sdce_job_t      job,
  output logic                     job_valid
);

  logic [11:0]  block_bytes, block_bytes_next;
  logic [1:0]   resp_pending, resp_pending_next;
  logic [7:0]   resp_length, resp_length_next;
  logic [7:0]   resp_bit_count, resp_bit_count_next;
  logic [135:0] resp_shift, resp_shift_next;
  logic [6:0]   resp_crc, resp_crc_next;
  logic [5:0]   expected_index, expected_index_next;
  logic         data_active, data_active_next;
  logic         data_started, data_started_next;
  logic [14:0]  data_bit_count, data_bit_count_next;
  logic [7:0]   data_shift, data_shift_next;
  logic [15:0]  running_crc16, running_crc16_next;
  logic [15:0]  received_crc16, received_crc16_next;
  logic [15:0]  blocks_left, blocks_left_next;

  // next state and job for the offered item
  always_comb begin
    logic        err;
    logic        finish;
    logic [7:0]  len_v;
    logic [11:0] nb;
    logic [14:0] dbits;
    logic [14:0] total;
    logic [7:0]  sh;
    err    = 1'b0;
    finish = 1'b0;
    len_v  = '0;
    nb     = '0;
    dbits  = '0;
    total  = '0;
    sh     = '0;
    block_bytes_next    = cfg_write ? cfg_data : block_bytes;
    resp_pending_next   = resp_pending;
    resp_length_next    = resp_length;
    resp_bit_count_next = resp_bit_count;
    resp_shift_next     = resp_shift;
    resp_crc_next       = resp_crc;
    expected_index_next = expected_index;
    data_active_next    = data_active;
    data_started_next   = data_started;
    data_bit_count_next = data_bit_count;
    data_shift_next     = data_shift;
    running_crc16_next  = running_crc16;
    received_crc16_next = received_crc16;
    blocks_left_next    = blocks_left;
    job       = '0;
    job_valid = 1'b0;

    if (in_item.mode == sdce_pkg::MODE_START) begin
      // new command frame, drops anything running
      resp_length_next    = '0;
      resp_bit_count_next = '0;
      resp_shift_next     = '0;
      resp_crc_next       = '0;
      data_started_next   = 1'b0;
      data_bit_count_next = '0;
      data_shift_next     = '0;
      running_crc16_next  = '0;
      received_crc16_next = '0;
      expected_index_next = in_item.cmd_index;
      resp_pending_next   = in_item.resp_type;
      data_active_next    = 1'b0;
      blocks_left_next    = '0;
      if (in_item.data_expected && in_item.block_count != '0 && block_bytes != '0) begin
        data_active_next = 1'b1;
        blocks_left_next = in_item.block_count;
      end
      job.is_start = 1'b1;
      job.frame    = {sdce_pkg::CMD_START, in_item.cmd_index, in_item.argument};
      job.done     = (in_item.resp_type == sdce_pkg::RESP_NONE) && !data_active_next;
      job.status   = sdce_pkg::STATUS_OK;
      job_valid    = 1'b1;
    end else if (resp_pending != sdce_pkg::RESP_NONE || data_active) begin
      // response line
      if (resp_pending != sdce_pkg::RESP_NONE) begin
        len_v = resp_length;
        if (!in_item.cmd_level && len_v == '0) begin
          len_v = (resp_pending == sdce_pkg::RESP_R2) ?
                  8'(sdce_pkg::LONG_RESP_BITS) : 8'(sdce_pkg::SHORT_RESP_BITS);
        end
        resp_length_next = len_v;
        if (len_v != '0) begin
          if (resp_bit_count < len_v) begin
            resp_shift_next     = {resp_shift[134:0], in_item.cmd_level};
            resp_bit_count_next = resp_bit_count + 8'd1;
            if (resp_bit_count < 8'(sdce_pkg::CRC7_BITS)) begin
              resp_crc_next = sdce_pkg::crc7_step(resp_crc, in_item.cmd_level);
            end
          end else begin
            if (resp_pending == sdce_pkg::RESP_R1 && resp_shift[7:0] != {resp_crc, 1'b1}) begin
              err        = 1'b1;
              job.status = sdce_pkg::STATUS_CRC_ERR;
            end else if (resp_pending == sdce_pkg::RESP_R1 &&
                         resp_shift[47:40] != {2'b00, expected_index}) begin
              err        = 1'b1;
              job.status = sdce_pkg::STATUS_INDEX_ERR;
            end
            if (!err) begin
              if (resp_pending == sdce_pkg::RESP_R2) begin
                job.num_words = 3'd4;
                job.words[0]  = resp_shift[127:96];
                job.words[1]  = resp_shift[95:64];
                job.words[2]  = resp_shift[63:32];
                job.words[3]  = resp_shift[31:0];
              end else begin
                job.num_words = 3'd1;
                job.words[0]  = resp_shift[39:8];
              end
              resp_pending_next   = sdce_pkg::RESP_NONE;
              resp_length_next    = '0;
              resp_bit_count_next = '0;
            end
          end
        end
      end

      // data line
      if (!err && data_active) begin
        if (!in_item.dat_level && !data_started) begin
          data_started_next   = 1'b1;
          data_bit_count_next = '0;
          data_shift_next     = '0;
          running_crc16_next  = '0;
        end else if (data_started) begin
          nb    = (block_bytes > 12'(sdce_pkg::MAX_BLOCK_BYTES)) ?
                  12'(sdce_pkg::MAX_BLOCK_BYTES) : block_bytes;
          dbits = {nb, 3'b000};
          total = dbits + 15'(sdce_pkg::CRC16_BITS);
          if (data_bit_count < total) begin
            if (data_bit_count < dbits) begin
              sh              = {data_shift[6:0], in_item.dat_level};
              data_shift_next = sh;
              // crc takes whole bytes only
              if (data_bit_count[2:0] == 3'b111) begin
                job.byte_valid     = 1'b1;
                job.data_byte      = sh;
                running_crc16_next = sdce_pkg::crc16_byte(running_crc16, sh);
              end
            end else begin
              received_crc16_next = {received_crc16[14:0], in_item.dat_level};
            end
            data_bit_count_next = data_bit_count + 15'd1;
          end else if (received_crc16 != running_crc16) begin
            err        = 1'b1;
            job.status = sdce_pkg::STATUS_CRC_ERR;
          end else begin
            blocks_left_next    = blocks_left - 16'd1;
            data_started_next   = 1'b0;
            data_bit_count_next = '0;
            data_shift_next     = '0;
            if (blocks_left == 16'd1) begin
              data_active_next = 1'b0;
            end
          end
        end
      end

      // transaction end
      finish = err ||
               (resp_pending_next == sdce_pkg::RESP_NONE && !data_active_next);
      if (finish) begin
        job.done            = 1'b1;
        resp_pending_next   = sdce_pkg::RESP_NONE;
        resp_length_next    = '0;
        resp_bit_count_next = '0;
        resp_shift_next     = '0;
        resp_crc_next       = '0;
        data_active_next    = 1'b0;
        data_started_next   = 1'b0;
        data_bit_count_next = '0;
        data_shift_next     = '0;
        running_crc16_next  = '0;
        received_crc16_next = '0;
        blocks_left_next    = '0;
      end
      job_valid = finish || job.byte_valid || (job.num_words != '0);
    end
  end

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes    <= 12'd512;
      resp_pending   <= sdce_pkg::RESP_NONE;
      resp_length    <= '0;
      resp_bit_count <= '0;
      resp_shift     <= '0;
      resp_crc       <= '0;
      expected_index <= '0;
      data_active    <= 1'b0;
      data_started   <= 1'b0;
      data_bit_count <= '0;
      data_shift     <= '0;
      running_crc16  <= '0;
      received_crc16 <= '0;
      blocks_left    <= '0;
    end else begin
      block_bytes <= block_bytes_next;
      if (accept) begin
        resp_pending   <= resp_pending_next;
        resp_length    <= resp_length_next;
        resp_bit_count <= resp_bit_count_next;
        resp_shift     <= resp_shift_next;
        resp_crc       <= resp_crc_next;
        expected_index <= expected_index_next;
        data_active    <= data_active_next;
        data_started   <= data_started_next;
        data_bit_count <= data_bit_count_next;
        data_shift     <= data_shift_next;
        running_crc16  <= running_crc16_next;
        received_crc16 <= received_crc16_next;
        blocks_left    <= blocks_left_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sdce_job_fifo.sv
// short job queue between front and back end
`default_nettype none
module sdce_job_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire sdce_pkg::sdce_job_t wr_data,
  output logic                     full,
  input  wire logic                rd_en,
  output sdce_pkg::sdce_job_t      rd_data,
  output logic                     not_empty
);

  localparam int unsigned PW = $clog2(sdce_pkg::FIFO_DEPTH);

  sdce_pkg::sdce_job_t mem [sdce_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(sdce_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sdce_back.sv
// back end: expands jobs into result items, serial crc7 for the command frame
`default_nettype none
module sdce_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sdce_pkg::sdce_job_t job,
  input  wire logic                job_avail,
  output logic                     job_take,
  output sdce_pkg::sdce_out_t      out_item,
  output logic                     empty,
  input  wire logic                pop
);

  sdce_pkg::sdce_job_t cur;
  logic                cur_valid;
  logic [5:0]          step;
  logic [6:0]          crc;
  logic                out_valid;
  logic [5:0]          total;
  logic                is_last;
  logic                advance;
  logic [5:0]          bit_sel;
  sdce_pkg::sdce_out_t res;

  assign empty   = !out_valid;
  assign advance = cur_valid && (!out_valid || pop);
  assign total   = cur.is_start ?
                   (6'(sdce_pkg::CMD_BITS) + 6'(cur.done)) :
                   (6'(cur.num_words) + 6'(cur.byte_valid) + 6'(cur.done));
  assign is_last = (step == total - 6'd1);
  assign job_take = job_avail && (!cur_valid || (advance && is_last));
  assign bit_sel = 6'd39 - step;

  // result for the current step
  always_comb begin
    res = '0;
    res.last = is_last;
    if (cur.is_start) begin
      if (step < 6'(sdce_pkg::CRC7_BITS)) begin
        res.kind        = sdce_pkg::KIND_CMD_BIT;
        res.cmd_out_bit = cur.frame[bit_sel];
      end else if (step < 6'(sdce_pkg::CMD_BITS - 1)) begin
        res.kind        = sdce_pkg::KIND_CMD_BIT;
        res.cmd_out_bit = crc[6];
      end else if (step == 6'(sdce_pkg::CMD_BITS - 1)) begin
        res.kind        = sdce_pkg::KIND_CMD_BIT;
        res.cmd_out_bit = 1'b1;
      end else begin
        res.kind   = sdce_pkg::KIND_DONE;
        res.status = cur.status;
      end
    end else begin
      if (step < 6'(cur.num_words)) begin
        res.kind       = sdce_pkg::KIND_RESP_WORD;
        res.resp_word  = cur.words[step[1:0]];
        res.word_index = step[1:0];
      end else if (step == 6'(cur.num_words) && cur.byte_valid) begin
        res.kind      = sdce_pkg::KIND_DATA_BYTE;
        res.data_byte = cur.data_byte;
      end else begin
        res.kind   = sdce_pkg::KIND_DONE;
        res.status = cur.status;
      end
    end
  end

  // current job, step counter and command crc
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      crc       <= '0;
    end else begin
      if (job_take) begin
        cur_valid <= 1'b1;
        step      <= '0;
        crc       <= '0;
      end else if (advance) begin
        step <= step + 6'd1;
        if (is_last) begin
          cur_valid <= 1'b0;
        end
        if (step < 6'(sdce_pkg::CRC7_BITS)) begin
          crc <= sdce_pkg::crc7_step(crc, cur.frame[bit_sel]);
        end else begin
          crc <= {crc[5:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

endmodule
`default_nettype wire

// File: test/sdce_tb_pkg.sv
// crc helpers shared by the sd engine checker and stimulus
package sdce_tb_pkg;

  // crc7 over a 40-bit header, returned in bits 7..1 with the end bit set
  function automatic logic [7:0] crc7_hdr(input logic [39:0] v);
    logic [7:0] c;
    logic fb;
    c = 8'h00;
    for (int i = 39; i >= 0; i--) begin
      fb = c[7] ^ v[i];
      c = {c[6:0], 1'b0} ^ (fb ? 8'h12 : 8'h00);
    end
    return c | 8'h01;
  endfunction

  // crc16 (0x1021) advanced by one byte, msb first
  function automatic logic [15:0] crc16_upd(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = {r[14:0], 1'b0} ^ (r[15] ? 16'h1021 : 16'h0000);
    end
    return r;
  endfunction

endpackage

// File: test/sdce_checker.sv
// checker: tracks the engine's transfers, predicts results and compares them
module sdce_checker
  import sdce_pkg::*;
  import sdce_tb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  sdce_in_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  sdce_out_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [11:0] cfg_data,
  output int        fails,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  sdce_out_t expected_results[$];

  // engine state as the predictor sees it
  logic [11:0] blk_bytes;
  logic [1:0]  resp_want;
  int          resp_len;
  int          resp_cnt;
  logic [7:0]  resp_buf[17];
  logic [5:0]  cmd_idx;
  logic        dat_on;
  logic        dat_run;
  int          dat_cnt;
  logic [7:0]  dat_sr;
  logic [15:0] crc_calc;
  logic [15:0] crc_rx;
  logic [15:0] blocks_todo;

  assign pending = expected_results.size();

  task automatic drop_transaction();
    resp_want = RESP_NONE;
    resp_len = 0;
    resp_cnt = 0;
    foreach (resp_buf[i]) resp_buf[i] = 8'h00;
    dat_on = 1'b0;
    dat_run = 1'b0;
    dat_cnt = 0;
    dat_sr = 8'h00;
    crc_calc = 16'h0000;
    crc_rx = 16'h0000;
    blocks_todo = 16'h0000;
  endtask

  function automatic sdce_out_t mk(input logic [1:0] k, input logic b, input logic [7:0] d,
                                   input logic [31:0] w, input logic [1:0] wi,
                                   input logic [1:0] st);
    sdce_out_t o;
    o = '0;
    o.kind = k;
    o.cmd_out_bit = b;
    o.data_byte = d;
    o.resp_word = w;
    o.word_index = wi;
    o.status = st;
    return o;
  endfunction

  // work out the results of one accepted item
  task automatic predict_item(input sdce_in_t it);
    sdce_out_t r[$];
    logic [47:0] frame;
    logic [1:0]  st;
    logic        err;
    int          k;
    int          nw;
    int          nb;
    int          dbits;
    logic [31:0] w;
    st = STATUS_OK;
    err = 1'b0;
    if (it.mode == MODE_START) begin
      drop_transaction();
      frame[47:8] = {2'b01, it.cmd_index, it.argument};
      frame[7:0] = crc7_hdr(frame[47:8]);
      for (int i = 47; i >= 0; i--)
        r.push_back(mk(KIND_CMD_BIT, frame[i], 8'h00, 32'h0, 2'd0, STATUS_OK));
      cmd_idx = it.cmd_index;
      resp_want = it.resp_type;
      if (it.data_expected && it.block_count != 16'h0 && blk_bytes != 12'h0) begin
        dat_on = 1'b1;
        blocks_todo = it.block_count;
      end
    end else if (resp_want == RESP_NONE && !dat_on) begin
      return;
    end else begin
      // response on the command line
      if (resp_want != RESP_NONE) begin
        if (!it.cmd_level && resp_len == 0)
          resp_len = (resp_want == RESP_R2) ? int'(LONG_RESP_BITS) : int'(SHORT_RESP_BITS);
        if (resp_len != 0) begin
          if (resp_cnt < resp_len) begin
            k = (resp_cnt >> 3) % 17;
            resp_buf[k] = {resp_buf[k][6:0], it.cmd_level};
            resp_cnt++;
          end else begin
            if (resp_want == RESP_R1) begin
              if (resp_buf[5] != crc7_hdr({resp_buf[0], resp_buf[1], resp_buf[2],
                                           resp_buf[3], resp_buf[4]})) begin
                err = 1'b1;
                st = STATUS_CRC_ERR;
              end else if (resp_buf[0] != {2'b00, cmd_idx}) begin
                err = 1'b1;
                st = STATUS_INDEX_ERR;
              end
            end
            if (!err) begin
              nw = (resp_want == RESP_R2) ? 4 : 1;
              for (int i = 0; i < nw; i++) begin
                w = {resp_buf[1+4*i], resp_buf[2+4*i], resp_buf[3+4*i], resp_buf[4+4*i]};
                r.push_back(mk(KIND_RESP_WORD, 1'b0, 8'h00, w, 2'(i), STATUS_OK));
              end
              resp_want = RESP_NONE;
              resp_len = 0;
              resp_cnt = 0;
            end
          end
        end
      end
      // data blocks on dat0
      if (!err && dat_on) begin
        if (!it.dat_level && !dat_run) begin
          dat_run = 1'b1;
          dat_cnt = 0;
          dat_sr = 8'h00;
          crc_calc = 16'h0000;
        end else if (dat_run) begin
          nb = (blk_bytes > MAX_BLOCK_BYTES) ? int'(MAX_BLOCK_BYTES) : int'(blk_bytes);
          dbits = nb * 8;
          if (dat_cnt < dbits + 16) begin
            if (dat_cnt < dbits) begin
              dat_sr = {dat_sr[6:0], it.dat_level};
              if ((dat_cnt & 7) == 7) begin
                r.push_back(mk(KIND_DATA_BYTE, 1'b0, dat_sr, 32'h0, 2'd0, STATUS_OK));
                crc_calc = crc16_upd(crc_calc, dat_sr);
              end
            end else begin
              crc_rx = {crc_rx[14:0], it.dat_level};
            end
            dat_cnt++;
          end else if (crc_rx != crc_calc) begin
            err = 1'b1;
            st = STATUS_CRC_ERR;
          end else begin
            blocks_todo = blocks_todo - 16'd1;
            dat_run = 1'b0;
            dat_cnt = 0;
            dat_sr = 8'h00;
            if (blocks_todo == 16'h0) dat_on = 1'b0;
          end
        end
      end
    end
    // transaction end, on error or when nothing is left
    if (err || (resp_want == RESP_NONE && !dat_on)) begin
      r.push_back(mk(KIND_DONE, 1'b0, 8'h00, 32'h0, 2'd0, st));
      drop_transaction();
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    foreach (r[i]) expected_results.push_back(r[i]);
  endtask

  // watch each transfer at the rising edge
  always @(posedge clk) begin
    sdce_out_t e;
    if (rst) begin
      blk_bytes = 12'd512;
      cmd_idx = '0;
      drop_transaction();
      expected_results.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) blk_bytes = cfg_data;
      if (push && !full) predict_item(in_item);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result kind=%0d actual=%h", $time, out_item.kind,
                   out_item);
        end else begin
          e = expected_results.pop_front();
          if (out_item.kind !== e.kind || out_item.cmd_out_bit !== e.cmd_out_bit ||
              out_item.data_byte !== e.data_byte || out_item.resp_word !== e.resp_word ||
              out_item.word_index !== e.word_index || out_item.status !== e.status ||
              out_item.last !== e.last) begin
            fails++;
            $display("%0t: mismatch expected kind=%0d bit=%0d byte=%h word=%h wi=%0d",
                     $time, e.kind, e.cmd_out_bit, e.data_byte, e.resp_word, e.word_index,
                     " st=%0d last=%0d", e.status, e.last);
            $display("%0t:          actual kind=%0d bit=%0d byte=%h word=%h wi=%0d",
                     $time, out_item.kind, out_item.cmd_out_bit, out_item.data_byte,
                     out_item.resp_word, out_item.word_index,
                     " st=%0d last=%0d", out_item.status, out_item.last);
          end
        end
      end
    end
  end

endmodule

// File: test/tb.sv
// testbench top: drives sd engine commands and bus ticks, reports the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdce_pkg::*;
  import sdce_tb_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  sdce_in_t    in_item;
  logic        empty;
  logic        pop;
  sdce_out_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;
  int          fails;
  int          pending;

  int          blk_now;
  int          burst_left;
  int          items_sent;
  logic        hold_req;
  int          wait_cnt;

  sd_bus_command_response_engine_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  sdce_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // receiver: stall pattern redrawn from time to time out of three kinds, one long hold-off on request
  initial begin
    int hold;
    int pat;
    int cyc;
    bit held;
    pop = 1'b0;
    hold = 0;
    pat = 0;
    cyc = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) pat = $urandom_range(0, 2);
      cyc++;
      if (hold_req && !held) begin
        hold = 400;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        pop = 1'b0;
      end else begin
        case (pat)
          0: pop = 1'b1;
          1: pop = ($urandom_range(0, 3) != 0);
          default: pop = ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // one input transfer, sender idles in random gaps between bursts
  task automatic send(input sdce_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        push = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    push = 1'b1;
    in_item = it;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  function automatic sdce_in_t rand_item(input logic m);
    sdce_in_t it;
    it = $bits(sdce_in_t)'({$urandom, $urandom});
    it.mode = m;
    return it;
  endfunction

  task automatic send_tick(input logic c, input logic d);
    sdce_in_t it;
    it = rand_item(MODE_TICK);
    it.cmd_level = c;
    it.dat_level = d;
    send(it);
  endtask

  // idle both sides, then write block_bytes
  task automatic write_block_bytes(input logic [11:0] v);
    @(negedge clk);
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    blk_now = int'(v);
  endtask

  // one command with its response and data on the lines
  // flaw: 0 clean, 1 bad response crc, 2 wrong response index, 3 bad data crc
  task automatic run_cmd(input logic [5:0] idx, input logic [31:0] arg, input logic [1:0] rt,
                         input logic dx, input logic [15:0] bc, input int nblk,
                         input int flaw);
    sdce_in_t    st;
    bit          cq[$];
    bit          dq[$];
    logic [39:0] hdr;
    logic [7:0]  crc;
    logic [7:0]  b;
    logic [15:0] c16;
    int          nb;
    int          len;
    st = rand_item(MODE_START);
    st.cmd_index = idx;
    st.argument = arg;
    st.resp_type = rt;
    st.data_expected = dx;
    st.block_count = bc;
    send(st);
    // command line response
    if (rt != RESP_NONE) begin
      repeat ($urandom_range(0, 5)) cq.push_back(1'b1);
      if (rt == RESP_R1) begin
        hdr = {2'b00, (flaw == 2) ? (idx ^ 6'h01) : idx, arg};
        crc = crc7_hdr(hdr);
        if (flaw == 1) crc ^= 8'h02;
        for (int i = 39; i >= 0; i--) cq.push_back(hdr[i]);
        for (int i = 7; i >= 0; i--) cq.push_back(crc[i]);
      end else begin
        len = (rt == RESP_R2) ? int'(LONG_RESP_BITS) : int'(SHORT_RESP_BITS);
        cq.push_back(1'b0);
        repeat (len - 1) cq.push_back(1'($urandom_range(0, 1)));
      end
    end
    // dat0 blocks
    nb = (blk_now > MAX_BLOCK_BYTES) ? int'(MAX_BLOCK_BYTES) : blk_now;
    if (dx && bc != 16'h0 && nb != 0) begin
      for (int k = 0; k < nblk; k++) begin
        repeat ($urandom_range(0, 4)) dq.push_back(1'b1);
        dq.push_back(1'b0);
        c16 = 16'h0000;
        for (int j = 0; j < nb; j++) begin
          b = 8'($urandom);
          c16 = crc16_upd(c16, b);
          for (int i = 7; i >= 0; i--) dq.push_back(b[i]);
        end
        if (flaw == 3 && k == nblk - 1) c16 ^= 16'h0100;
        for (int i = 15; i >= 0; i--) dq.push_back(c16[i]);
        dq.push_back(1'b1);
      end
    end
    len = (cq.size() > dq.size()) ? cq.size() : dq.size();
    for (int i = 0; i < len + 2; i++)
      send_tick(i < cq.size() ? cq[i] : 1'b1, i < dq.size() ? dq[i] : 1'b1);
  endtask

  // stimulus
  initial begin
    int goal;
    int sel;
    int n;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    items_sent = 0;
    blk_now = 512;
    n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle tick, each response type, data crc error, zero and oversized blocks
    send_tick(1'b0, 1'b0);
    write_block_bytes(12'd1);
    run_cmd(6'd0, 32'h0000_0000, RESP_NONE, 1'b0, 16'h0000, 0, 0);
    run_cmd(6'd63, 32'hFFFF_FFFF, RESP_R1, 1'b1, 16'd2, 2, 0);
    run_cmd(6'd17, 32'h1234_5678, RESP_R2, 1'b0, 16'hFFFF, 0, 0);
    run_cmd(6'd41, 32'hA5A5_5A5A, RESP_R3, 1'b1, 16'd1, 1, 3);
    write_block_bytes(12'd0);
    run_cmd(6'd9, $urandom, RESP_NONE, 1'b1, 16'd5, 0, 0);
    // oversized block left waiting, then dropped by the next start
    write_block_bytes(12'd4095);
    run_cmd(6'd18, $urandom, RESP_NONE, 1'b1, 16'd1, 0, 0);

    // pressure: receiver holds off while start items fill the queue
    hold_req = 1'b1;
    repeat (8) send(rand_item(MODE_START));
    hold_req = 1'b0;

    // random phase with small block sizes
    goal = 330;
    while (items_sent < goal) begin
      if (n % 3 == 0) write_block_bytes(12'($urandom_range(1, 4)));
      n++;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        run_cmd(6'($urandom), $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                16'($urandom_range(1, 2)), 2,
                ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 3)) : 0);
      end else begin
        send(rand_item(MODE_START));
        repeat ($urandom_range(1, 12)) send(rand_item(MODE_TICK));
      end
    end

    // drain
    @(negedge clk);
    push = 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 200000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
